FILE: rtl/core/bsrmv_pkg.sv
`default_nettype none
package bsrmv_pkg;

   // Block edge; every lane-indexed structure follows from it.
   localparam int BLOCK_DIM = 8;
   localparam int LANE_W    = (BLOCK_DIM > 1) ? $clog2(BLOCK_DIM) : 1;

   // Fixed field widths of the channels.
   localparam int IDX_W     = 3;
   localparam int DATA_W    = 32;
   localparam int SLICE_W   = 64;
   localparam int BYTE_W    = 8;
   localparam int NUM_BYTES = SLICE_W / BYTE_W;
   localparam int PROD_W    = 2 * BYTE_W;
   localparam int DOT_W     = PROD_W + LANE_W;
   localparam int CSR_IDX_W = 2;

   localparam logic [IDX_W:0] BLOCK_DIM_LIM = (IDX_W + 1)'(BLOCK_DIM);

   typedef enum logic {
      REQ_ACC,
      REQ_FIN
   } req_kind_type;

   typedef enum logic {
      LAYOUT_ROW,
      LAYOUT_COL
   } layout_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALPHA,
      CSR_BETA,
      CSR_LAYOUT
   } csr_addr_type;

   typedef logic signed [PROD_W-1:0] prod_type;

   // Control of the word held in the product stage.
   typedef struct packed {
      req_kind_type      kind;
      logic [LANE_W-1:0] lane;
   } item_ctrl_type;

   // A finish handed from the merge stage to the scaling stage.
   typedef struct packed {
      logic [DATA_W-1:0] sum;
      logic [DATA_W-1:0] y_old;
      logic [LANE_W-1:0] lane;
   } fin_type;

endpackage
`default_nettype wire

FILE: rtl/core/bsrmv_req_if.sv
`default_nettype none
interface bsrmv_req_if;
   import bsrmv_pkg::*;

   logic               valid;
   logic               ready;
   logic               req_type;
   logic [IDX_W-1:0]   slice_index;
   logic [SLICE_W-1:0] matrix_slice;
   logic [SLICE_W-1:0] vector_segment;
   logic [DATA_W-1:0]  y_old;

   modport source (output valid, req_type, slice_index, matrix_slice, vector_segment, y_old,
                   input ready);
   modport sink (input valid, req_type, slice_index, matrix_slice, vector_segment, y_old,
                 output ready);
endinterface
`default_nettype wire

FILE: rtl/core/bsrmv_rsp_if.sv
`default_nettype none
interface bsrmv_rsp_if;
   import bsrmv_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] y_new;
   logic [IDX_W-1:0]  lane;

   modport source (output valid, y_new, lane, input ready);
   modport sink (input valid, y_new, lane, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/bsrmv_lane.sv
`default_nettype none
module bsrmv_lane (
   input  wire logic                     clock,
   input  wire logic                     load,
   input  wire logic signed [7:0]        m_byte,
   input  wire logic signed [7:0]        x_byte,
   output bsrmv_pkg::prod_type           prod
);
   import bsrmv_pkg::*;

   prod_type prod_ff;
   prod_type prod_in;

   // Both operands are signed, so the product is sign-correct at 16 bits.
   assign prod_in = m_byte * x_byte;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;
endmodule
`default_nettype wire

FILE: rtl/core/bsrmv_merge.sv
`default_nettype none
module bsrmv_merge (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      go,
   input  wire bsrmv_pkg::item_ctrl_type  ctrl,
   input  wire bsrmv_pkg::layout_type     layout,
   input  wire bsrmv_pkg::prod_type       prods [bsrmv_pkg::BLOCK_DIM],
   output bsrmv_pkg::fin_type             fin_sum
);
   import bsrmv_pkg::*;

   logic [DATA_W-1:0]       lane_sums_ff [BLOCK_DIM];
   logic [DATA_W-1:0]       lane_sums_in [BLOCK_DIM];
   logic signed [DOT_W-1:0] dot_sum;

   // Row layout folds all lane products into one dot product.
   always_comb begin
      dot_sum = '0;
      for (int k = 0; k < BLOCK_DIM; k++) begin
         dot_sum = dot_sum + DOT_W'(prods[k]);
      end
   end

   always_comb begin
      for (int i = 0; i < BLOCK_DIM; i++) begin
         lane_sums_in[i] = lane_sums_ff[i];
      end
      if (go) begin
         if (ctrl.kind == REQ_FIN) begin
            lane_sums_in[ctrl.lane] = '0;
         end else if (layout == LAYOUT_ROW) begin
            lane_sums_in[ctrl.lane] = lane_sums_ff[ctrl.lane] + DATA_W'(dot_sum);
         end else begin
            for (int i = 0; i < BLOCK_DIM; i++) begin
               lane_sums_in[i] = lane_sums_ff[i] + DATA_W'(prods[i]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BLOCK_DIM; i++) begin
            lane_sums_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < BLOCK_DIM; i++) begin
            lane_sums_ff[i] <= lane_sums_in[i];
         end
      end
   end

   // The sum is read before this cycle's clear, so it holds every earlier word.
   assign fin_sum.sum   = lane_sums_ff[ctrl.lane];
   assign fin_sum.y_old = '0;
   assign fin_sum.lane  = ctrl.lane;
endmodule
`default_nettype wire

FILE: rtl/core/bsrmv_scale.sv
`default_nettype none
module bsrmv_scale (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         load,
   input  wire bsrmv_pkg::fin_type           fin,
   input  wire logic [bsrmv_pkg::DATA_W-1:0] alpha,
   input  wire logic [bsrmv_pkg::DATA_W-1:0] beta,
   output logic                              s2_free,
   bsrmv_rsp_if.source                       rsp
);
   import bsrmv_pkg::*;

   logic              s2_valid_ff;
   logic              s2_valid_in;
   logic [DATA_W-1:0] prod_a_ff;
   logic [DATA_W-1:0] prod_b_ff;
   logic [LANE_W-1:0] lane_s2_ff;
   logic [DATA_W-1:0] prod_a_in;
   logic [DATA_W-1:0] prod_b_in;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [DATA_W-1:0] y_new_ff;
   logic [LANE_W-1:0] lane_out_ff;

   logic              out_free;
   logic              s2_move;

   // Only the low 32 bits are kept; a zero beta gives a zero term.
   assign prod_a_in = alpha * fin.sum;
   assign prod_b_in = beta * fin.y_old;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign s2_move  = s2_valid_ff && out_free;
   assign s2_free  = !s2_valid_ff || out_free;

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (load) begin
         s2_valid_in = 1'b1;
      end else if (s2_move) begin
         s2_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s2_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_a_ff  <= prod_a_in;
         prod_b_ff  <= prod_b_in;
         lane_s2_ff <= fin.lane;
      end
      if (s2_move) begin
         y_new_ff    <= prod_a_ff + prod_b_ff;
         lane_out_ff <= lane_s2_ff;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.y_new = y_new_ff;
   assign rsp.lane  = IDX_W'(lane_out_ff);
endmodule
`default_nettype wire

FILE: rtl/core/bsr_8x8_matrix_vector_multiply.sv
`default_nettype none
// Channel   | Dir | Handshake           | Payload
// ----------+-----+---------------------+------------------------------------------------
// req_ch    | in  | valid / ready       | req_type, slice_index, matrix_slice,
//           |     |                     | vector_segment, y_old
// rsp_ch    | out | valid / ready       | y_new, lane
// csr       | in  | csr_we (no stall)   | csr_index, csr_wdata
//
// One word is taken every cycle unless a waiting finish holds the input. The eight
// lane multipliers and the merge adder tree each take one slice per cycle, so
// accumulate words stream back to back. A finish word passes the product stage,
// the scaling stage with its own 32 x 32 multipliers, then the output register.
// Reset is synchronous and clears the lane sums, alpha to one, beta to zero and
// row layout. A stalled result holds in the output register. Words keep flowing
// until a finish word meets a full scaling stage; that finish then waits in the
// product stage and holds the input, accumulate words included, until it moves.
module bsr_8x8_matrix_vector_multiply (
   input  wire logic                             clock,
   input  wire logic                             reset,
   bsrmv_req_if.sink                             req_ch,
   bsrmv_rsp_if.source                           rsp_ch,
   input  wire logic                             csr_we,
   input  wire logic [bsrmv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bsrmv_pkg::DATA_W-1:0]     csr_wdata
);
   import bsrmv_pkg::*;

   // Configuration registers.
   logic [DATA_W-1:0] alpha_ff;
   logic [DATA_W-1:0] beta_ff;
   layout_type        layout_ff;

   // Product stage: the lane products plus the control of the word behind them.
   logic              p_valid_ff;
   logic              p_valid_in;
   item_ctrl_type     p_ctrl_ff;
   item_ctrl_type     p_ctrl_in;
   logic [DATA_W-1:0] p_y_old_ff;

   logic              in_take;
   logic              in_range;
   logic              p_go;
   logic              s2_free;

   logic [BYTE_W-1:0] vec_bytes [NUM_BYTES];
   logic [BYTE_W-1:0] x_sel     [BLOCK_DIM];
   prod_type          prods     [BLOCK_DIM];
   fin_type           merge_fin;
   fin_type           scale_fin;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= DATA_W'(1);
         beta_ff   <= '0;
         layout_ff <= LAYOUT_ROW;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ALPHA:  alpha_ff  <= csr_wdata;
            CSR_BETA:   beta_ff   <= csr_wdata;
            CSR_LAYOUT: layout_ff <= layout_type'(csr_wdata[0]);
            default: ;
         endcase
      end
   end

   // A word with a slice or lane outside the block is taken and dropped.
   assign in_range = {1'b0, req_ch.slice_index} < BLOCK_DIM_LIM;
   assign in_take  = req_ch.valid && req_ch.ready;

   // An accumulate always retires; a finish needs room in the scaling stage.
   assign p_go         = p_valid_ff && ((p_ctrl_ff.kind == REQ_ACC) || s2_free);
   assign req_ch.ready = !p_valid_ff || p_go;

   always_comb begin
      p_valid_in = p_valid_ff;
      if (in_take) begin
         p_valid_in = in_range;
      end else if (p_go) begin
         p_valid_in = 1'b0;
      end
      p_ctrl_in.kind = req_kind_type'(req_ch.req_type);
      p_ctrl_in.lane = req_ch.slice_index[LANE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         p_ctrl_ff  <= p_ctrl_in;
         p_y_old_ff <= req_ch.y_old;
      end
   end

   // Row layout pairs element k with x value k; column layout gives every lane
   // the x value picked by the slice number.
   always_comb begin
      for (int k = 0; k < NUM_BYTES; k++) begin
         vec_bytes[k] = req_ch.vector_segment[k*BYTE_W +: BYTE_W];
      end
      for (int k = 0; k < BLOCK_DIM; k++) begin
         x_sel[k] = (layout_ff == LAYOUT_ROW) ? vec_bytes[k]
                                              : vec_bytes[req_ch.slice_index];
      end
   end

   for (genvar g = 0; g < BLOCK_DIM; g++) begin : g_lane
      bsrmv_lane u_lane (
         .clock  (clock),
         .load   (in_take),
         .m_byte (req_ch.matrix_slice[g*BYTE_W +: BYTE_W]),
         .x_byte (x_sel[g]),
         .prod   (prods[g])
      );
   end

   bsrmv_merge u_merge (
      .clock   (clock),
      .reset   (reset),
      .go      (p_go),
      .ctrl    (p_ctrl_ff),
      .layout  (layout_ff),
      .prods   (prods),
      .fin_sum (merge_fin)
   );

   always_comb begin
      scale_fin       = merge_fin;
      scale_fin.y_old = p_y_old_ff;
   end

   bsrmv_scale u_scale (
      .clock   (clock),
      .reset   (reset),
      .load    (p_go && (p_ctrl_ff.kind == REQ_FIN)),
      .fin     (scale_fin),
      .alpha   (alpha_ff),
      .beta    (beta_ff),
      .s2_free (s2_free),
      .rsp     (rsp_ch)
   );
endmodule
`default_nettype wire

FILE: rtl/core/bsrmv_checker.sv
`default_nettype none
module bsrmv_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         req_type,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [bsrmv_pkg::DATA_W-1:0] rsp_y_new,
   input wire logic [bsrmv_pkg::IDX_W-1:0]  rsp_lane
);
   import bsrmv_pkg::*;

   logic fin_acc;

   assign fin_acc = req_valid && req_ready && (req_type == REQ_FIN);

   // A result waiting on the sink keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_y_new) && $stable(rsp_lane))
      else $error("result changed while stalled");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // With the output idle and no finish taken over the sampled history, no result
   // can appear: every finish drains out of the pipeline within that history.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && $past(!rsp_valid) && $past(!rsp_valid, 2) &&
      !fin_acc && $past(!fin_acc) && $past(!fin_acc, 2) |=> !rsp_valid)
      else $error("result without a finish word");

   // A finish taken into an idle block never yields a result on the next cycle.
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      fin_acc && !rsp_valid && $past(!rsp_valid) && $past(!rsp_valid, 2) &&
      $past(!fin_acc) && $past(!fin_acc, 2) |=> !rsp_valid)
      else $error("result appeared too early");
endmodule

bind bsr_8x8_matrix_vector_multiply bsrmv_checker u_bsrmv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .req_type  (req_ch.req_type),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_y_new (rsp_ch.y_new),
   .rsp_lane  (rsp_ch.lane)
);
`default_nettype wire
